@@ rtl/core/jsr_pkg.sv @@
// ----------------------------------------------------------------------------
// jsr_pkg
// Shared widths, command codes and result flag type of the joint setpoint ramp.
// ----------------------------------------------------------------------------
package jsr_pkg;

   localparam int NUM_JOINTS_DEF = 7;
   localparam int POS_WIDTH_DEF  = 20;

   localparam int CMD_W   = 2;
   localparam int JOINT_W = 3;
   localparam int STEP_W  = 16;
   localparam int CNT_W   = 4;

   localparam logic [STEP_W-1:0] STEP_RESET = 16'd328;
   localparam logic [CNT_W-1:0]  CNT_MAX    = 4'd15;

   localparam logic [CMD_W-1:0] CMD_LIMITS = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_INIT   = 2'd3;

   typedef struct packed {
      logic joint_done;
      logic all_done;
      logic active;
      logic status;
   } rsp_flags_type;

endpackage

@@ rtl/core/jsr_req_if.sv @@
// ----------------------------------------------------------------------------
// jsr_req_if
// Request channel of the joint setpoint ramp: valid/ready plus payload.
// ----------------------------------------------------------------------------
interface jsr_req_if
   import jsr_pkg::*;
#(
   parameter int POS_WIDTH = POS_WIDTH_DEF
);
   logic                        valid;
   logic                        ready;
   logic [CMD_W-1:0]            cmd;
   logic [JOINT_W-1:0]          joint;
   logic signed [POS_WIDTH-1:0] measured;
   logic signed [POS_WIDTH-1:0] target;
   logic signed [POS_WIDTH-1:0] limit_low;
   logic signed [POS_WIDTH-1:0] limit_high;
   logic                        last;

   modport source (
      output valid, cmd, joint, measured, target, limit_low, limit_high, last,
      input  ready
   );
   modport sink (
      input  valid, cmd, joint, measured, target, limit_low, limit_high, last,
      output ready
   );
endinterface

@@ rtl/core/jsr_rsp_if.sv @@
// ----------------------------------------------------------------------------
// jsr_rsp_if
// Result channel of the joint setpoint ramp: valid/ready plus payload.
// ----------------------------------------------------------------------------
interface jsr_rsp_if
   import jsr_pkg::*;
#(
   parameter int POS_WIDTH = POS_WIDTH_DEF
);
   logic                        valid;
   logic                        ready;
   logic [JOINT_W-1:0]          joint_out;
   logic signed [POS_WIDTH-1:0] desired;
   logic                        joint_done;
   logic                        all_done;
   logic                        active;
   logic                        status;

   modport source (
      output valid, joint_out, desired, joint_done, all_done, active, status,
      input  ready
   );
   modport sink (
      input  valid, joint_out, desired, joint_done, all_done, active, status,
      output ready
   );
endinterface

@@ rtl/core/joint_setpoint_ramp_top.sv @@
// Pipeline: a request is taken into the input register, and its result is
// computed from there and written into the result register.
// Throughput: one request per cycle unless the result channel stalls; the joint
// tables are read and updated in the single stage between the two registers.
// Reset (synchronous, active high) clears motion state, limits to full range,
// desired positions to zero and step size to 328; targets are not cleared.
// ----------------------------------------------------------------------------
// joint_setpoint_ramp_top
// Multi-joint position ramp generator with per-joint limits and targets.
// ----------------------------------------------------------------------------
module joint_setpoint_ramp_top
   import jsr_pkg::*;
#(
   parameter int NUM_JOINTS = NUM_JOINTS_DEF,
   parameter int POS_WIDTH  = POS_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   jsr_req_if.sink           req,
   jsr_rsp_if.source         rsp,
   input  logic              csr_we,
   input  logic [STEP_W-1:0] csr_wdata
);

   logic                        stg_valid;
   logic                        stg_ready;
   logic [CMD_W-1:0]            stg_cmd;
   logic [JOINT_W-1:0]          stg_joint;
   logic signed [POS_WIDTH-1:0] stg_measured;
   logic signed [POS_WIDTH-1:0] stg_target;
   logic signed [POS_WIDTH-1:0] stg_limit_low;
   logic signed [POS_WIDTH-1:0] stg_limit_high;
   logic                        stg_last;
   rsp_flags_type               out_flags;

   jsr_in_reg #(
      .POS_WIDTH (POS_WIDTH)
   ) u_in_reg (
      .clock          (clock),
      .reset          (reset),
      .req            (req),
      .stg_valid      (stg_valid),
      .stg_ready      (stg_ready),
      .stg_cmd        (stg_cmd),
      .stg_joint      (stg_joint),
      .stg_measured   (stg_measured),
      .stg_target     (stg_target),
      .stg_limit_low  (stg_limit_low),
      .stg_limit_high (stg_limit_high),
      .stg_last       (stg_last)
   );

   jsr_core #(
      .NUM_JOINTS (NUM_JOINTS),
      .POS_WIDTH  (POS_WIDTH)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .stg_valid      (stg_valid),
      .stg_ready      (stg_ready),
      .stg_cmd        (stg_cmd),
      .stg_joint      (stg_joint),
      .stg_measured   (stg_measured),
      .stg_target     (stg_target),
      .stg_limit_low  (stg_limit_low),
      .stg_limit_high (stg_limit_high),
      .stg_last       (stg_last),
      .out_valid      (rsp.valid),
      .out_ready      (rsp.ready),
      .out_joint      (rsp.joint_out),
      .out_desired    (rsp.desired),
      .out_flags      (out_flags)
   );

   assign rsp.joint_done = out_flags.joint_done;
   assign rsp.all_done   = out_flags.all_done;
   assign rsp.active     = out_flags.active;
   assign rsp.status     = out_flags.status;

endmodule

@@ rtl/core/jsr_in_reg.sv @@
// ----------------------------------------------------------------------------
// jsr_in_reg
// Input register stage: captures one request per cycle when the core can move.
// ----------------------------------------------------------------------------
module jsr_in_reg
   import jsr_pkg::*;
#(
   parameter int POS_WIDTH = POS_WIDTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   jsr_req_if.sink                     req,
   output logic                        stg_valid,
   input  logic                        stg_ready,
   output logic [CMD_W-1:0]            stg_cmd,
   output logic [JOINT_W-1:0]          stg_joint,
   output logic signed [POS_WIDTH-1:0] stg_measured,
   output logic signed [POS_WIDTH-1:0] stg_target,
   output logic signed [POS_WIDTH-1:0] stg_limit_low,
   output logic signed [POS_WIDTH-1:0] stg_limit_high,
   output logic                        stg_last
);

   logic                        valid_ff;
   logic                        valid_in;
   logic [CMD_W-1:0]            cmd_ff;
   logic [JOINT_W-1:0]          joint_ff;
   logic signed [POS_WIDTH-1:0] measured_ff;
   logic signed [POS_WIDTH-1:0] target_ff;
   logic signed [POS_WIDTH-1:0] limit_low_ff;
   logic signed [POS_WIDTH-1:0] limit_high_ff;
   logic                        last_ff;
   logic                        take;

   assign req.ready = !valid_ff || stg_ready;
   assign take      = req.valid && req.ready;
   assign valid_in  = take || (valid_ff && !stg_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         cmd_ff        <= req.cmd;
         joint_ff      <= req.joint;
         measured_ff   <= req.measured;
         target_ff     <= req.target;
         limit_low_ff  <= req.limit_low;
         limit_high_ff <= req.limit_high;
         last_ff       <= req.last;
      end
   end

   assign stg_valid      = valid_ff;
   assign stg_cmd        = cmd_ff;
   assign stg_joint      = joint_ff;
   assign stg_measured   = measured_ff;
   assign stg_target     = target_ff;
   assign stg_limit_low  = limit_low_ff;
   assign stg_limit_high = limit_high_ff;
   assign stg_last       = last_ff;

endmodule

@@ rtl/core/jsr_core.sv @@
// ----------------------------------------------------------------------------
// jsr_core
// Joint tables, motion state and ramp step; writes the result register.
// ----------------------------------------------------------------------------
module jsr_core
   import jsr_pkg::*;
#(
   parameter int NUM_JOINTS = NUM_JOINTS_DEF,
   parameter int POS_WIDTH  = POS_WIDTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [STEP_W-1:0]           csr_wdata,
   input  logic                        stg_valid,
   output logic                        stg_ready,
   input  logic [CMD_W-1:0]            stg_cmd,
   input  logic [JOINT_W-1:0]          stg_joint,
   input  logic signed [POS_WIDTH-1:0] stg_measured,
   input  logic signed [POS_WIDTH-1:0] stg_target,
   input  logic signed [POS_WIDTH-1:0] stg_limit_low,
   input  logic signed [POS_WIDTH-1:0] stg_limit_high,
   input  logic                        stg_last,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [JOINT_W-1:0]          out_joint,
   output logic signed [POS_WIDTH-1:0] out_desired,
   output rsp_flags_type               out_flags
);

   localparam int IDX_W = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
   localparam int EW    = ((POS_WIDTH > STEP_W) ? POS_WIDTH : STEP_W) + 2;
   localparam int JCW   = JOINT_W + 2;

   localparam logic signed [POS_WIDTH-1:0] POS_MIN = {1'b1, {(POS_WIDTH-1){1'b0}}};
   localparam logic signed [POS_WIDTH-1:0] POS_MAX = {1'b0, {(POS_WIDTH-1){1'b1}}};
   localparam logic [NUM_JOINTS-1:0]       ALL_ONES = {NUM_JOINTS{1'b1}};

   logic signed [POS_WIDTH-1:0] desired_ff [NUM_JOINTS];
   logic signed [POS_WIDTH-1:0] target_ff  [NUM_JOINTS];
   logic signed [POS_WIDTH-1:0] lower_ff   [NUM_JOINTS];
   logic signed [POS_WIDTH-1:0] upper_ff   [NUM_JOINTS];
   logic [NUM_JOINTS-1:0]       dir_ff, dir_in;
   logic [NUM_JOINTS-1:0]       done_ff, done_in;
   logic                        armed_ff, armed_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in, cnt_inc;
   logic [STEP_W-1:0]           step_ff;

   logic                        rsp_valid_ff;
   logic [JOINT_W-1:0]          rsp_joint_ff;
   logic signed [POS_WIDTH-1:0] rsp_desired_ff, rsp_desired_in;
   rsp_flags_type               rsp_flags_ff, rsp_flags_in;

   logic                        advance;
   logic                        fire;
   logic                        jvalid;
   logic [IDX_W-1:0]            idx;
   logic [NUM_JOINTS-1:0]       jbit;
   logic                        down;
   logic signed [EW-1:0]        meas_x, step_x, d_x, lo_x, hi_x, tgt_x;
   logic signed [POS_WIDTH-1:0] d_val;
   logic                        d_fin;
   logic                        des_wr;
   logic signed [POS_WIDTH-1:0] des_val;
   logic                        lim_wr;
   logic                        tgt_wr;

   assign advance   = !rsp_valid_ff || out_ready;
   assign stg_ready = advance;
   assign fire      = stg_valid && advance;

   assign jvalid = {2'b00, stg_joint} < JCW'(NUM_JOINTS);
   assign idx    = IDX_W'(stg_joint);
   assign jbit   = jvalid ? (NUM_JOINTS'(1) << idx) : '0;
   assign down   = |(dir_ff & jbit);

   // ramp step in a widened domain so the step can never wrap
   assign meas_x = EW'(stg_measured);
   assign step_x = signed'({{(EW-STEP_W){1'b0}}, step_ff});
   assign d_x    = down ? (meas_x - step_x) : (meas_x + step_x);
   assign lo_x   = EW'(lower_ff[idx]);
   assign hi_x   = EW'(upper_ff[idx]);
   assign tgt_x  = EW'(target_ff[idx]);

   always_comb begin
      d_fin = 1'b1;
      d_val = POS_WIDTH'(d_x);
      if (d_x <= lo_x) begin
         d_val = lower_ff[idx];
      end else if (d_x >= hi_x) begin
         d_val = upper_ff[idx];
      end else if ((!down && d_x >= tgt_x) || (down && d_x <= tgt_x)) begin
         d_val = target_ff[idx];
      end else begin
         d_fin = 1'b0;
      end
   end

   assign cnt_inc = (cnt_ff == CNT_MAX) ? CNT_MAX : cnt_ff + 1'b1;

   always_comb begin
      dir_in        = dir_ff;
      done_in       = done_ff;
      armed_in      = armed_ff;
      cnt_in        = cnt_ff;
      des_wr        = 1'b0;
      des_val       = d_val;
      lim_wr        = 1'b0;
      tgt_wr        = 1'b0;
      rsp_flags_in  = '0;
      case (stg_cmd)
         CMD_LIMITS: begin
            lim_wr = jvalid;
         end
         CMD_LOAD: begin
            tgt_wr = jvalid;
            if (stg_measured > stg_target) begin
               dir_in = dir_ff | jbit;
            end else begin
               dir_in = dir_ff & ~jbit;
            end
            cnt_in = cnt_inc;
            if (stg_last) begin
               cnt_in = '0;
               if ({1'b0, cnt_inc} == (CNT_W+1)'(NUM_JOINTS)) begin
                  done_in  = '0;
                  armed_in = 1'b1;
               end else begin
                  armed_in            = 1'b0;
                  rsp_flags_in.status = 1'b1;
               end
            end
         end
         CMD_TICK: begin
            if (armed_ff && jvalid && !(|(done_ff & jbit))) begin
               des_wr = 1'b1;
               if (d_fin) begin
                  done_in = done_ff | jbit;
               end
               if (done_in == ALL_ONES) begin
                  armed_in = 1'b0;
               end
            end
         end
         CMD_INIT: begin
            des_wr   = jvalid;
            des_val  = stg_measured;
            armed_in = 1'b0;
         end
         default: begin
            armed_in = armed_ff;
         end
      endcase
      rsp_flags_in.joint_done = |(done_in & jbit);
      rsp_flags_in.all_done   = (done_in == ALL_ONES);
      rsp_flags_in.active     = armed_in;
   end

   always_comb begin
      if (!jvalid) begin
         rsp_desired_in = '0;
      end else if (des_wr) begin
         rsp_desired_in = des_val;
      end else begin
         rsp_desired_in = desired_ff[idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff       <= '0;
         done_ff      <= '0;
         armed_ff     <= 1'b0;
         cnt_ff       <= '0;
         step_ff      <= STEP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            step_ff <= csr_wdata;
         end
         if (fire) begin
            dir_ff   <= dir_in;
            done_ff  <= done_in;
            armed_ff <= armed_in;
            cnt_ff   <= cnt_in;
         end
         if (advance) begin
            rsp_valid_ff <= stg_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_JOINTS; i++) begin
            desired_ff[i] <= '0;
            lower_ff[i]   <= POS_MIN;
            upper_ff[i]   <= POS_MAX;
         end
      end else if (fire) begin
         if (des_wr) begin
            desired_ff[idx] <= des_val;
         end
         if (lim_wr) begin
            lower_ff[idx] <= stg_limit_low;
            upper_ff[idx] <= stg_limit_high;
         end
      end
   end

   // targets hold no reset value, only loads write them
   always_ff @(posedge clock) begin
      if (fire && tgt_wr) begin
         target_ff[idx] <= stg_target;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_joint_ff   <= stg_joint;
         rsp_desired_ff <= rsp_desired_in;
         rsp_flags_ff   <= rsp_flags_in;
      end
   end

   assign out_valid   = rsp_valid_ff;
   assign out_joint   = rsp_joint_ff;
   assign out_desired = rsp_desired_ff;
   assign out_flags   = rsp_flags_ff;

endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the joint setpoint ramp: directed corner requests,
// then random motions (limits, load bursts, tick rounds) under several step
// sizes, with random stalls on both channels and a long result back-pressure.
// ----------------------------------------------------------------------------
module testbench
   import jsr_pkg::*;
();

   localparam int NJ          = NUM_JOINTS_DEF;
   localparam int POS_W       = POS_WIDTH_DEF;
   localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
   localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
   localparam int CYCLE_LIMIT = 300000;

   typedef struct {
      logic [CMD_W-1:0]        cmd;
      logic [JOINT_W-1:0]      joint;
      logic signed [POS_W-1:0] measured;
      logic signed [POS_W-1:0] target;
      logic signed [POS_W-1:0] limit_low;
      logic signed [POS_W-1:0] limit_high;
      logic                    last;
   } ramp_req_type;

   typedef struct {
      logic [JOINT_W-1:0]      joint;
      logic signed [POS_W-1:0] desired;
      rsp_flags_type           flags;
   } ramp_rsp_type;

   logic              clock;
   logic              reset;
   logic              csr_we;
   logic [STEP_W-1:0] csr_wdata;

   jsr_req_if #(.POS_WIDTH(POS_W)) req_bus ();
   jsr_rsp_if #(.POS_WIDTH(POS_W)) rsp_bus ();

   joint_setpoint_ramp_top #(
      .NUM_JOINTS (NJ),
      .POS_WIDTH  (POS_W)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .rsp       (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // ramp state mirrored by the predictor
   logic signed [POS_W-1:0] pos_cmd   [NJ];
   logic signed [POS_W-1:0] goal_pos  [NJ];
   logic signed [POS_W-1:0] low_lim   [NJ];
   logic signed [POS_W-1:0] high_lim  [NJ];
   logic [NJ-1:0]           moving_down;
   logic [NJ-1:0]           joint_finished;
   logic                    motion_armed;
   logic [CNT_W-1:0]        loads_seen;
   logic [STEP_W-1:0]       ramp_step;

   ramp_rsp_type expected_results [$];
   int        sent_count;
   int        checked_count;
   int        mismatch_count;
   int        bursts_armed;
   int        bursts_rejected;
   int        motions_run;
   bit        traffic_gaps;
   int        rx_hold_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic ramp_req_type make_req(input logic [CMD_W-1:0] cmd,
                                             input logic [JOINT_W-1:0] joint,
                                             input logic signed [POS_W-1:0] measured,
                                             input logic signed [POS_W-1:0] target,
                                             input logic signed [POS_W-1:0] limit_low,
                                             input logic signed [POS_W-1:0] limit_high,
                                             input logic last);
      ramp_req_type r;
      r.cmd        = cmd;
      r.joint      = joint;
      r.measured   = measured;
      r.target     = target;
      r.limit_low  = limit_low;
      r.limit_high = limit_high;
      r.last       = last;
      return r;
   endfunction

   function automatic logic signed [POS_W-1:0] clip_pos(input int v);
      if (v > POS_MAX) return POS_MAX;
      if (v < POS_MIN) return POS_MIN;
      return POS_W'(v);
   endfunction

   function automatic void add_expected(input ramp_rsp_type e);
      expected_results = {expected_results, e};
   endfunction

   // advances the mirrored state by one request and returns its result
   function automatic ramp_rsp_type predict_ramp(input ramp_req_type r);
      ramp_rsp_type  o;
      int            d;
      int            meas_i;
      logic          in_range;
      logic          down;
      logic [NJ-1:0] sel;
      in_range = (r.joint < NJ);
      sel = '0;
      if (in_range) sel[r.joint] = 1'b1;
      meas_i = int'(r.measured);
      o.flags.status = 1'b0;
      case (r.cmd)
         CMD_LIMITS: begin
            if (in_range) begin
               low_lim[r.joint]  = r.limit_low;
               high_lim[r.joint] = r.limit_high;
            end
         end
         CMD_LOAD: begin
            if (in_range) begin
               goal_pos[r.joint]    = r.target;
               moving_down[r.joint] = (r.measured > r.target);
            end
            if (loads_seen != CNT_MAX) loads_seen = loads_seen + 1'b1;
            if (r.last) begin
               if (loads_seen == NJ) begin
                  joint_finished = '0;
                  motion_armed   = 1'b1;
                  bursts_armed++;
               end else begin
                  motion_armed   = 1'b0;
                  o.flags.status = 1'b1;
                  bursts_rejected++;
               end
               loads_seen = '0;
            end
         end
         CMD_TICK: begin
            if (motion_armed && in_range && !joint_finished[r.joint]) begin
               down = moving_down[r.joint];
               d = down ? meas_i - int'(ramp_step) : meas_i + int'(ramp_step);
               // lower limit is tested first, so it wins on crossed limits
               if (d <= low_lim[r.joint]) begin
                  d = int'(low_lim[r.joint]);
                  joint_finished[r.joint] = 1'b1;
               end else if (d >= high_lim[r.joint]) begin
                  d = int'(high_lim[r.joint]);
                  joint_finished[r.joint] = 1'b1;
               end else if ((!down && d >= goal_pos[r.joint]) ||
                            (down && d <= goal_pos[r.joint])) begin
                  d = int'(goal_pos[r.joint]);
                  joint_finished[r.joint] = 1'b1;
               end
               pos_cmd[r.joint] = d[POS_W-1:0];
               if (&joint_finished) motion_armed = 1'b0;
            end
         end
         default: begin
            if (in_range) pos_cmd[r.joint] = r.measured;
            motion_armed = 1'b0;
         end
      endcase
      o.joint            = r.joint;
      o.desired          = in_range ? pos_cmd[r.joint] : '0;
      o.flags.joint_done = |(joint_finished & sel);
      o.flags.all_done   = &joint_finished;
      o.flags.active     = motion_armed;
      return o;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      mismatch_count++;
      if (mismatch_count <= 40)
         $display("mismatch at result %0d (t=%0t): %s got %0d expected %0d",
                  checked_count, $realtime, what, got, want);
   endtask

   task automatic send_item(input ramp_req_type r);
      int gap;
      if (traffic_gaps && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 10);
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid      <= 1'b1;
      req_bus.cmd        <= r.cmd;
      req_bus.joint      <= r.joint;
      req_bus.measured   <= r.measured;
      req_bus.target     <= r.target;
      req_bus.limit_low  <= r.limit_low;
      req_bus.limit_high <= r.limit_high;
      req_bus.last       <= r.last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      add_expected(predict_ramp(r));
      sent_count++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_step(input logic [STEP_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      ramp_step = value;
   endtask

   // result checker
   always @(posedge clock) begin : result_check
      ramp_rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected result, joint_out", longint'(rsp_bus.joint_out), -1);
         end else begin
            want = expected_results.pop_front();
            if (rsp_bus.joint_out !== want.joint)
               report_mismatch("joint_out", longint'(rsp_bus.joint_out),
                               longint'(want.joint));
            if (rsp_bus.desired !== want.desired)
               report_mismatch("desired", longint'(rsp_bus.desired), longint'(want.desired));
            if (rsp_bus.joint_done !== want.flags.joint_done)
               report_mismatch("joint_done", longint'(rsp_bus.joint_done),
                               longint'(want.flags.joint_done));
            if (rsp_bus.all_done !== want.flags.all_done)
               report_mismatch("all_done", longint'(rsp_bus.all_done),
                               longint'(want.flags.all_done));
            if (rsp_bus.active !== want.flags.active)
               report_mismatch("active", longint'(rsp_bus.active),
                               longint'(want.flags.active));
            if (rsp_bus.status !== want.flags.status)
               report_mismatch("status", longint'(rsp_bus.status),
                               longint'(want.flags.status));
         end
         checked_count++;
      end
   end

   // result receiver: random stall bursts, plus a long hold when asked
   initial begin : result_receiver
      int n;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (rx_hold_cycles > 0) begin
            n = rx_hold_cycles;
            rx_hold_cycles = 0;
            rsp_bus.ready <= 1'b0;
            repeat (n - 1) @(negedge clock);
         end else if (traffic_gaps && $urandom_range(0, 5) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(0, 9)) @(negedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("timed out after %0d cycles with %0d results outstanding",
               CYCLE_LIMIT, expected_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // ticks and inits before any motion has been armed
   task automatic test_disarmed_ticks();
      send_item(make_req(CMD_TICK, 0, 12345, 0, 0, 0, 1'b0));
      send_item(make_req(CMD_TICK, 7, -1, -1, -1, -1, 1'b1));
      send_item(make_req(CMD_INIT, 1, POS_MIN, 0, 0, 0, 1'b0));
   endtask

   // limits (narrow, crossed, out of range joint) and a full burst that arms
   task automatic test_burst_arming();
      send_item(make_req(CMD_LIMITS, 2, 0, 0, -1000, 1000, 1'b0));
      send_item(make_req(CMD_LIMITS, 3, 0, 0, 500, -500, 1'b0));
      send_item(make_req(CMD_LIMITS, 7, 0, 0, 0, 0, 1'b0));
      send_item(make_req(CMD_LOAD, 0, 0, 1000, 0, 0, 1'b0));
      send_item(make_req(CMD_LOAD, 1, POS_MAX, POS_MIN, 0, 0, 1'b0));
      send_item(make_req(CMD_LOAD, 2, 0, 100000, 0, 0, 1'b0));
      send_item(make_req(CMD_LOAD, 3, 0, 0, 0, 0, 1'b0));
      send_item(make_req(CMD_LOAD, 4, 0, -100, 0, 0, 1'b0));
      send_item(make_req(CMD_LOAD, 5, POS_MIN, POS_MAX, 0, 0, 1'b0));
      send_item(make_req(CMD_LOAD, 6, POS_MAX, POS_MAX, 0, 0, 1'b1));
   endtask

   // target snap both ways, clamps at both limits, crossed limits, done joint
   task automatic test_ramp_clamping();
      send_item(make_req(CMD_TICK, 0, 0, 0, 0, 0, 1'b0));
      send_item(make_req(CMD_TICK, 0, 900, 0, 0, 0, 1'b0));
      send_item(make_req(CMD_TICK, 0, 5, 0, 0, 0, 1'b0));
      send_item(make_req(CMD_TICK, 1, -524200, 0, 0, 0, 1'b0));
      send_item(make_req(CMD_TICK, 2, 900, 0, 0, 0, 1'b0));
      send_item(make_req(CMD_TICK, 3, 0, 0, 0, 0, 1'b0));
      send_item(make_req(CMD_TICK, 4, 0, 0, 0, 0, 1'b0));
      send_item(make_req(CMD_TICK, 5, POS_MAX, 0, 0, 0, 1'b0));
      send_item(make_req(CMD_TICK, 6, POS_MAX, 0, 0, 0, 1'b0));
   endtask

   task automatic test_rejected_burst();
      send_item(make_req(CMD_LOAD, 7, 3, 4, 0, 0, 1'b1));
      send_item(make_req(CMD_INIT, 4, POS_MAX, 0, 0, 0, 1'b0));
      wait_drained();
   endtask

   // well-formed motion: optional limits, a shuffled burst, tick rounds, then an init if still armed
   task automatic run_motion();
      int cur [NJ];
      int goal [NJ];
      int order [NJ];
      int span;
      int j;
      int k;
      int pick;
      int tmp;
      int rounds;
      logic signed [POS_W-1:0] raw;
      span = int'(ramp_step) * 8 + 16;
      for (j = 0; j < NJ; j++) begin
         raw = POS_W'($urandom);
         cur[j] = int'(raw);
         goal[j] = int'(clip_pos(cur[j] + int'($urandom_range(0, 2 * span)) - span));
         order[j] = j;
      end
      for (j = NJ - 1; j > 0; j--) begin
         pick = $urandom_range(0, j);
         tmp = order[j];
         order[j] = order[pick];
         order[pick] = tmp;
      end
      for (j = 0; j < NJ; j++) begin
         case ($urandom_range(0, 7))
            0: send_item(make_req(CMD_LIMITS, JOINT_W'(j), POS_W'($urandom), POS_W'($urandom),
                  POS_MIN, POS_MAX, 1'b0));
            1: send_item(make_req(CMD_LIMITS, JOINT_W'(j), POS_W'($urandom), POS_W'($urandom),
                  clip_pos((cur[j] < goal[j] ? cur[j] : goal[j]) - int'($urandom_range(0, span))),
                  clip_pos((cur[j] > goal[j] ? cur[j] : goal[j]) + int'($urandom_range(0, span))),
                  1'b0));
            2: send_item(make_req(CMD_LIMITS, JOINT_W'(j), POS_W'($urandom), POS_W'($urandom),
                  clip_pos(cur[j] + int'($urandom_range(1, span))),
                  clip_pos(cur[j] - int'($urandom_range(1, span))), 1'b0));
            default: ;
         endcase
      end
      for (k = 0; k < NJ; k++)
         send_item(make_req(CMD_LOAD, JOINT_W'(order[k]), POS_W'(cur[order[k]]),
                            POS_W'(goal[order[k]]), POS_W'($urandom), POS_W'($urandom),
                            k == NJ - 1));
      rounds = 0;
      while (motion_armed && rounds < 12) begin
         for (j = 0; j < NJ; j++) begin
            if ($urandom_range(0, 7) != 0) begin
               send_item(make_req(CMD_TICK, JOINT_W'(j), POS_W'(cur[j]), POS_W'($urandom),
                                  POS_W'($urandom), POS_W'($urandom), 1'($urandom)));
               cur[j] = int'(clip_pos(int'(pos_cmd[j]) + int'($urandom_range(0, 6)) - 3));
            end
         end
         rounds++;
      end
      if (motion_armed) begin
         j = $urandom_range(0, NJ - 1);
         send_item(make_req(CMD_INIT, JOINT_W'(j), POS_W'(cur[j]), POS_W'($urandom),
                            POS_W'($urandom), POS_W'($urandom), 1'($urandom)));
      end
      motions_run++;
   endtask

   // burst of the wrong length, or of the right length with stray joints
   task automatic run_broken_burst();
      int n;
      int k;
      n = $urandom_range(1, 18);
      for (k = 0; k < n; k++)
         send_item(make_req(CMD_LOAD, JOINT_W'($urandom_range(0, 7)), POS_W'($urandom),
                            POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                            k == n - 1));
   endtask

   task automatic test_random_motions(input logic [STEP_W-1:0] step, input int quota,
                                      input bit gaps, input int hold);
      int first;
      int choice;
      wait_drained();
      write_step(step);
      traffic_gaps = gaps;
      if (hold > 0) rx_hold_cycles = hold;
      first = sent_count;
      while (sent_count - first < quota) begin
         choice = $urandom_range(0, 19);
         if (choice < 14) begin
            run_motion();
         end else if (choice < 16) begin
            run_broken_burst();
         end else begin
            send_item(make_req(CMD_W'($urandom), JOINT_W'($urandom), POS_W'($urandom),
                               POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                               1'($urandom)));
         end
      end
      wait_drained();
   endtask

   initial begin : main_sequence
      int i;
      reset          <= 1'b1;
      csr_we         <= 1'b0;
      csr_wdata      <= '0;
      req_bus.valid      <= 1'b0;
      req_bus.cmd        <= CMD_LIMITS;
      req_bus.joint      <= '0;
      req_bus.measured   <= '0;
      req_bus.target     <= '0;
      req_bus.limit_low  <= '0;
      req_bus.limit_high <= '0;
      req_bus.last       <= 1'b0;
      for (i = 0; i < NJ; i++) begin
         pos_cmd[i]  = '0;
         goal_pos[i] = '0;
         low_lim[i]  = POS_MIN;
         high_lim[i] = POS_MAX;
      end
      moving_down     = '0;
      joint_finished  = '0;
      motion_armed    = 1'b0;
      loads_seen      = '0;
      ramp_step       = STEP_RESET;
      sent_count      = 0;
      checked_count   = 0;
      mismatch_count  = 0;
      bursts_armed    = 0;
      bursts_rejected = 0;
      motions_run     = 0;
      traffic_gaps    = 1'b0;
      rx_hold_cycles  = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // the first burst writes every target, so no later tick reads an unset one
      test_disarmed_ticks();
      test_burst_arming();
      test_ramp_clamping();
      test_rejected_burst();

      test_random_motions(16'd1, 150, 1'b1, 0);
      test_random_motions(16'd0, 130, 1'b1, 0);
      test_random_motions(16'd65535, 150, 1'b1, 80);
      test_random_motions(STEP_W'($urandom_range(2, 65534)), 170, 1'b1, 0);
      test_random_motions(STEP_RESET, 170, 1'b1, 0);
      test_random_motions(STEP_W'($urandom_range(2, 65534)), 190, 1'b0, 0);

      repeat (8) @(posedge clock);
      if (expected_results.size() != 0)
         report_mismatch("results never arrived", 0, longint'(expected_results.size()));

      $display("ramp run: %0d requests sent, %0d results checked, %0d random motions",
               sent_count, checked_count, motions_run);
      $display("step sizes 0, 1, 328, 65535 and random; %0d bursts armed, %0d rejected",
               bursts_armed, bursts_rejected);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/jsr_pkg.sv
rtl/core/jsr_req_if.sv
rtl/core/jsr_rsp_if.sv
rtl/core/jsr_in_reg.sv
rtl/core/jsr_core.sv
rtl/core/joint_setpoint_ramp_top.sv
verif/testbench.sv
